/* rtl/srpb_pkg.sv */
package srpb_pkg;

  localparam int RowCount    = 1024;
  localparam int RowCapacity = 16;
  localparam int ColumnCount = 1024;

  localparam int RowW    = 10;
  localparam int ColW    = 10;
  localparam int PosW    = 4;
  localparam int CountW  = 15;
  localparam int RowAw   = (RowCount > 1) ? $clog2(RowCount) : 1;
  localparam int FillW   = $clog2(RowCapacity + 1);

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP
  } state_e;

  typedef struct packed {
    op_e             op;
    logic [RowW-1:0] row_index;
    logic [ColW-1:0] column_index;
  } in_word_t;

  typedef struct packed {
    logic [PosW-1:0]   position;
    logic              added;
    status_e           status;
    logic [CountW-1:0] nonzero_total;
  } out_word_t;

  typedef logic [RowCapacity-1:0][ColW-1:0] row_cols_t;

  typedef struct packed {
    logic [FillW-1:0] fill;
    row_cols_t        cols;
  } row_entry_t;

endpackage

/* rtl/sparse_row_pattern_builder_top.sv */
// An accepted input word and its row read are registered, then its result goes to the output register.
// No new word is taken until the last is through the read-modify-write of the row memory
// (the row is read, then ranked, shift-inserted and written back).
// The output register holds a result while stalled; a word in lookup waits for it.
// Reset: asynchronous, active low; then a clearing pass zeroes the fill of every one of the
// RowCount (1024) rows, during which no input word is accepted.
module sparse_row_pattern_builder_top import srpb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam logic [CountW-1:0] CountMax = '1;

  state_e state_q, state_d;
  logic [RowAw-1:0] clr_q, clr_d;
  logic             clr_last;

  // row memory: fill count and sorted column slots of each row
  row_entry_t row_mem [RowCount];
  row_entry_t rd_q;
  logic       rd_en;
  logic       we;
  logic [RowAw-1:0] wr_addr;
  row_entry_t wr_data;

  in_word_t req_q;
  logic     in_acc;
  logic     upd_fire;
  logic     clr_we;

  logic [CountW-1:0] count_q, count_d;
  logic      out_valid_q, out_valid_d;
  out_word_t out_q, out_d;

  logic                row_ok;
  logic [FillW-1:0]    fill;
  logic [RowCapacity-1:0] lt_vec;
  logic [RowCapacity-1:0] eq_vec;
  logic [FillW-1:0]    rank;
  logic                hit;
  logic                room;
  logic                do_write;
  row_cols_t           new_cols;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign clr_last = (clr_q == RowAw'(RowCount - 1));
  assign rd_en    = in_acc;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:  if (clr_last) state_d = S_IDLE;
      S_IDLE:   if (in_acc) state_d = S_LOOKUP;
      S_LOOKUP: if (upd_fire) state_d = S_IDLE;
      default:  state_d = S_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o = 1'b1;
    clr_we     = 1'b0;
    upd_fire   = 1'b0;
    case (state_q)
      S_CLEAR:  clr_we = 1'b1;
      S_IDLE:   in_stall_o = 1'b0;
      S_LOOKUP: upd_fire = !out_valid_q || !out_stall_i;
      default:  in_stall_o = 1'b1;
    endcase
  end

  assign clr_d = clr_we ? clr_q + RowAw'(1) : clr_q;

  // rank the column against the stored slots
  assign row_ok = (int'(req_q.row_index) < RowCount);
  assign fill   = rd_q.fill;

  always_comb begin
    for (int k = 0; k < RowCapacity; k++) begin
      lt_vec[k] = (FillW'(k) < fill) && (rd_q.cols[k] < req_q.column_index);
      eq_vec[k] = (FillW'(k) < fill) && (rd_q.cols[k] == req_q.column_index);
    end
  end

  assign rank = FillW'($countones(lt_vec));
  assign hit  = |eq_vec;
  assign room = (fill < FillW'(RowCapacity));
  assign do_write = row_ok && (req_q.op == OP_INSERT) && !hit && room;

  // open a gap at the rank and drop the column in
  always_comb begin
    for (int j = 0; j < RowCapacity; j++) begin
      if (FillW'(j) < rank) begin
        new_cols[j] = rd_q.cols[j];
      end else if (FillW'(j) == rank) begin
        new_cols[j] = req_q.column_index;
      end else begin
        new_cols[j] = rd_q.cols[j - ((j > 0) ? 1 : 0)];
      end
    end
  end

  assign we      = clr_we || (upd_fire && do_write);
  assign wr_addr = clr_we ? clr_q : req_q.row_index[RowAw-1:0];

  always_comb begin
    if (clr_we) begin
      wr_data = '0;
    end else begin
      wr_data.fill = fill + FillW'(1);
      wr_data.cols = new_cols;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      row_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= row_mem[in_word_i.row_index[RowAw-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_word_i;
    end
  end

  // result and running count
  always_comb begin
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (upd_fire) begin
      if (do_write && (count_q != CountMax)) begin
        count_d = count_q + CountW'(1);
      end
      out_valid_d          = 1'b1;
      out_d.position       = '0;
      out_d.added          = 1'b0;
      out_d.nonzero_total  = count_d;
      if (!row_ok) begin
        out_d.status = (req_q.op == OP_SEARCH) ? ST_MISS : ST_FULL;
      end else if (hit) begin
        out_d.status   = ST_OK;
        out_d.position = PosW'(rank);
      end else if (req_q.op == OP_SEARCH) begin
        out_d.status = ST_MISS;
      end else if (!room) begin
        out_d.status = ST_FULL;
      end else begin
        out_d.status   = ST_OK;
        out_d.position = PosW'(rank);
        out_d.added    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
